// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the RTL of the entry packer datapath.
// Depends on nothing; each macro takes a label, clock, reset and property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property on the rising clock edge, disabled while reset is low.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Assert that a condition on one edge implies a consequence on the next edge.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/zsep_pkg.sv -----
// Package for the stored ZIP entry packer: payload structs, codes, constants.
// Used by every module of the block.
package zsep_pkg;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_word;
        logic [2:0]  out_bytes;
        logic        out_last;
    } out_item_t;

    localparam logic [1:0] MODE_NAME   = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_DATA   = 2'd2;
    localparam logic [1:0] MODE_FINISH = 2'd3;

    localparam logic CFG_DOS_TIME = 1'b0;
    localparam logic CFG_DOS_DATE = 1'b1;

    // Field selector codes for the datapath word mux.
    typedef enum logic [3:0] {
        F_CONST  = 4'd0,
        F_TIME   = 4'd1,
        F_DATE   = 4'd2,
        F_NLEN   = 4'd3,
        F_CRC    = 4'd4,
        F_COUNT  = 4'd5,
        F_CDSIZE = 4'd6,
        F_CDOFF  = 4'd7,
        F_NAME   = 4'd8,
        F_DATA   = 4'd9
    } field_t;

    // Header field list entry: selector, constant value, byte count.
    typedef struct packed {
        field_t      sel;
        logic [31:0] value;
        logic [2:0]  nbytes;
    } field_entry_t;

    localparam int LOC_LEN = 11;
    localparam int TRL_LEN = 29;
    localparam int TRL_NAME_AT = 21;

    function automatic field_entry_t local_field(input logic [3:0] idx);
        field_entry_t e;
        e = '{F_CONST, 32'd0, 3'd2};
        case (idx)
            4'd0:    e = '{F_CONST, 32'h04034b50, 3'd4};
            4'd1:    e = '{F_CONST, 32'd20, 3'd2};
            4'd2:    e = '{F_CONST, 32'h0008, 3'd2};
            4'd4:    e = '{F_TIME, 32'd0, 3'd2};
            4'd5:    e = '{F_DATE, 32'd0, 3'd2};
            4'd6:    e = '{F_CONST, 32'd0, 3'd4};
            4'd7:    e = '{F_CONST, 32'd0, 3'd4};
            4'd8:    e = '{F_CONST, 32'd0, 3'd4};
            4'd9:    e = '{F_NLEN, 32'd0, 3'd2};
            default: e = '{F_CONST, 32'd0, 3'd2};
        endcase
        return e;
    endfunction

    // Trailer fields; the central name sits at TRL_NAME_AT.
    function automatic field_entry_t trailer_field(input logic [4:0] idx);
        field_entry_t e;
        e = '{F_CONST, 32'd0, 3'd2};
        case (idx)
            5'd0:    e = '{F_CONST, 32'h08074b50, 3'd4};
            5'd1:    e = '{F_CRC, 32'd0, 3'd4};
            5'd2:    e = '{F_COUNT, 32'd0, 3'd4};
            5'd3:    e = '{F_COUNT, 32'd0, 3'd4};
            5'd4:    e = '{F_CONST, 32'h02014b50, 3'd4};
            5'd5:    e = '{F_CONST, 32'd20, 3'd2};
            5'd6:    e = '{F_CONST, 32'd20, 3'd2};
            5'd7:    e = '{F_CONST, 32'h0008, 3'd2};
            5'd9:    e = '{F_TIME, 32'd0, 3'd2};
            5'd10:   e = '{F_DATE, 32'd0, 3'd2};
            5'd11:   e = '{F_CRC, 32'd0, 3'd4};
            5'd12:   e = '{F_COUNT, 32'd0, 3'd4};
            5'd13:   e = '{F_COUNT, 32'd0, 3'd4};
            5'd14:   e = '{F_NLEN, 32'd0, 3'd2};
            5'd19:   e = '{F_CONST, 32'd0, 3'd4};
            5'd20:   e = '{F_CONST, 32'd0, 3'd4};
            5'd21:   e = '{F_CONST, 32'h06054b50, 3'd4};
            5'd24:   e = '{F_CONST, 32'd1, 3'd2};
            5'd25:   e = '{F_CONST, 32'd1, 3'd2};
            5'd26:   e = '{F_CDSIZE, 32'd0, 3'd4};
            5'd27:   e = '{F_CDOFF, 32'd0, 3'd4};
            default: e = '{F_CONST, 32'd0, 3'd2};
        endcase
        return e;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       name_wr;
        logic       data_upd;
        logic       clr_entry;
        logic       clr_name;
        logic       cap_field;
        field_entry_t field;
        logic       last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       name_full;
        logic [5:0] name_len;
    } dp_stat_t;

endpackage

// ----- rtl/core/zsep_ctrl.sv -----
// Controller of the entry packer: phase tracking and header sequencing.
// Depends on zsep_pkg; drives zsep_datapath through command structs.
module zsep_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  zsep_pkg::in_item_t  s_item,
    input  logic                obuf_free,
    input  zsep_pkg::dp_stat_t  stat,
    output zsep_pkg::dp_cmd_t   cmd,
    output logic [5:0]          name_idx
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOCAL  = 6'b000010,
        ST_LNAME  = 6'b000100,
        ST_STREAM = 6'b001000,
        ST_TRAIL  = 6'b010000,
        ST_TNAME  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  idx_reg, idx_next;
    logic [5:0]  nidx_reg, nidx_next;
    logic        take;
    logic        emit_ok;
    logic        has_name;

    // The name store read is registered, so its address is taken from the next-state index.
    assign s_ready  = (state_reg == ST_IDLE || state_reg == ST_STREAM) && obuf_free;
    assign take     = s_valid && s_ready;
    assign emit_ok  = obuf_free;
    assign name_idx = nidx_next;
    assign has_name = stat.name_len != 6'd0;

    // Sequencing of header, name and trailer results.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        nidx_next  = nidx_reg;
        cmd        = '0;
        cmd.field  = '{zsep_pkg::F_CONST, 32'd0, 3'd2};
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    case (s_item.mode)
                        zsep_pkg::MODE_NAME: cmd.name_wr = !stat.name_full;
                        zsep_pkg::MODE_START: begin
                            cmd.clr_entry = 1'b1;
                            state_next    = ST_LOCAL;
                            idx_next      = 5'd0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOCAL: begin
                if (emit_ok) begin
                    cmd.cap_field = 1'b1;
                    cmd.field     = zsep_pkg::local_field(idx_reg[3:0]);
                    if (idx_reg == 5'(zsep_pkg::LOC_LEN - 1)) begin
                        cmd.last   = !has_name;
                        nidx_next  = 6'd0;
                        state_next = has_name ? ST_LNAME : ST_STREAM;
                    end else begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
            end
            ST_LNAME: begin
                if (emit_ok) begin
                    cmd.cap_field = 1'b1;
                    cmd.field     = '{zsep_pkg::F_NAME, 32'd0, 3'd1};
                    nidx_next     = nidx_reg + 6'd1;
                    if (nidx_next == stat.name_len) begin
                        cmd.last   = 1'b1;
                        state_next = ST_STREAM;
                    end
                end
            end
            ST_STREAM: begin
                if (take) begin
                    case (s_item.mode)
                        zsep_pkg::MODE_DATA: begin
                            cmd.data_upd  = 1'b1;
                            cmd.cap_field = 1'b1;
                            cmd.field     = '{zsep_pkg::F_DATA, 32'd0, 3'd1};
                            cmd.last      = 1'b1;
                        end
                        zsep_pkg::MODE_FINISH: begin
                            state_next = ST_TRAIL;
                            idx_next   = 5'd0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_TRAIL: begin
                if (emit_ok) begin
                    if (idx_reg == 5'(zsep_pkg::TRL_NAME_AT) && has_name &&
                        nidx_reg == 6'd0) begin
                        state_next = ST_TNAME;
                    end else begin
                        cmd.cap_field = 1'b1;
                        cmd.field     = zsep_pkg::trailer_field(idx_reg);
                        nidx_next     = 6'd0;
                        if (idx_reg == 5'(zsep_pkg::TRL_LEN - 1)) begin
                            cmd.last     = 1'b1;
                            cmd.clr_name = 1'b1;
                            state_next   = ST_IDLE;
                        end else begin
                            idx_next = idx_reg + 5'd1;
                        end
                    end
                end
            end
            ST_TNAME: begin
                if (emit_ok) begin
                    cmd.cap_field = 1'b1;
                    cmd.field     = '{zsep_pkg::F_NAME, 32'd0, 3'd1};
                    nidx_next     = nidx_reg + 6'd1;
                    if (nidx_next == stat.name_len) begin
                        // Keep nidx nonzero so the end record follows.
                        state_next = ST_TRAIL;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 5'd0;
            nidx_reg  <= 6'd0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            nidx_reg  <= nidx_next;
        end
    end

endmodule

// ----- rtl/core/zsep_datapath.sv -----
// Datapath of the entry packer: name store, CRC-32, count, field mux, output register.
// Depends on zsep_pkg and assert_macros.svh; commanded by zsep_ctrl.
`include "assert_macros.svh"
module zsep_datapath #(
    parameter int NAME_MAX = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  zsep_pkg::in_item_t  s_item,
    input  zsep_pkg::dp_cmd_t   cmd,
    input  logic [5:0]          name_idx,
    input  logic                cfg_wr,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                m_ready,
    output logic                m_valid,
    output zsep_pkg::out_item_t m_item,
    output logic                obuf_free,
    output zsep_pkg::dp_stat_t  stat
);

    localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

    logic [7:0]  name_mem [NAME_MAX];
    logic [7:0]  name_rd_reg;
    logic [5:0]  nlen_reg;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] count_reg;
    logic [15:0] time_reg, date_reg;
    logic        mvalid_reg;
    zsep_pkg::out_item_t mitem_reg;
    logic [31:0] word;
    logic [31:0] mask;

    assign stat.name_len  = nlen_reg;
    assign stat.name_full = nlen_reg >= 6'(NAME_MAX);
    assign obuf_free      = !mvalid_reg || m_ready;
    assign m_valid        = mvalid_reg;
    assign m_item         = mitem_reg;

    // Bitwise CRC-32 update of one byte.
    always_comb begin
        crc_next = crc_reg ^ {24'd0, s_item.data_byte};
        for (int k = 0; k < 8; k++) begin
            crc_next = crc_next[0] ? (32'hEDB88320 ^ (crc_next >> 1)) : (crc_next >> 1);
        end
    end

    // Field value selection.
    always_comb begin
        case (cmd.field.sel)
            zsep_pkg::F_TIME:   word = {16'd0, time_reg};
            zsep_pkg::F_DATE:   word = {16'd0, date_reg};
            zsep_pkg::F_NLEN:   word = {26'd0, nlen_reg};
            zsep_pkg::F_CRC:    word = ~crc_reg;
            zsep_pkg::F_COUNT:  word = count_reg;
            zsep_pkg::F_CDSIZE: word = 32'd46 + {26'd0, nlen_reg};
            zsep_pkg::F_CDOFF:  word = 32'd46 + {26'd0, nlen_reg} + count_reg;
            zsep_pkg::F_NAME:   word = {24'd0, name_rd_reg};
            zsep_pkg::F_DATA:   word = {24'd0, s_item.data_byte};
            default:            word = cmd.field.value;
        endcase
        case (cmd.field.nbytes)
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
    end

    // Name store writes and registered reads.
    always_ff @(posedge aclk) begin
        if (cmd.name_wr) begin
            name_mem[nlen_reg[AW-1:0]] <= s_item.data_byte;
        end
        name_rd_reg <= name_mem[name_idx[AW-1:0]];
    end

    // Entry state, configuration and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nlen_reg   <= 6'd0;
            crc_reg    <= 32'hFFFF_FFFF;
            count_reg  <= 32'd0;
            time_reg   <= 16'd0;
            date_reg   <= 16'd33;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (cfg_index == zsep_pkg::CFG_DOS_TIME) time_reg <= cfg_data;
                else date_reg <= cfg_data;
            end
            if (cmd.name_wr) nlen_reg <= nlen_reg + 6'd1;
            if (cmd.clr_name) nlen_reg <= 6'd0;
            if (cmd.clr_entry || cmd.clr_name) begin
                crc_reg   <= 32'hFFFF_FFFF;
                count_reg <= 32'd0;
            end else if (cmd.data_upd) begin
                crc_reg   <= crc_next;
                count_reg <= count_reg + 32'd1;
            end
            if (cmd.cap_field) mvalid_reg <= 1'b1;
            else if (m_ready) mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_field) begin
            mitem_reg.out_word  <= word & mask;
            mitem_reg.out_bytes <= cmd.field.nbytes;
            mitem_reg.out_last  <= cmd.last;
        end
    end

    `ASSERT_CLK(a_no_overwrite, aclk, aresetn, cmd.cap_field |-> obuf_free)
    `ASSERT_CLK(a_name_bound, aclk, aresetn, nlen_reg <= 6'(NAME_MAX))
    `ASSERT_NEXT(a_hold, aclk, aresetn, mvalid_reg && !m_ready, mvalid_reg && $stable(mitem_reg))

endmodule

// ----- rtl/core/zip_stored_entry_packer.sv -----
// Stored-mode one-entry ZIP packer. Name items are accepted while idle and the
// output register is free; data bytes pass at one per cycle while it is free,
// each registered into it. Start emits 11 header results plus one per name byte,
// one per cycle while the output is free; finish emits 29 results plus one per
// name byte likewise, pausing before any central name; no input is taken meanwhile.
// Reset (aresetn low, synchronous) clears phase, CRC, count, name length, registers.
module zip_stored_entry_packer #(
    parameter int NAME_MAX = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  zsep_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output zsep_pkg::out_item_t m_item,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_wr_data
);

    zsep_pkg::dp_cmd_t  cmd;
    zsep_pkg::dp_stat_t stat;
    logic               obuf_free;
    logic [5:0]         name_idx;

    zsep_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_item(s_item), .obuf_free(obuf_free), .stat(stat), .cmd(cmd),
        .name_idx(name_idx)
    );

    zsep_datapath #(.NAME_MAX(NAME_MAX)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_item(s_item), .cmd(cmd),
        .name_idx(name_idx), .cfg_wr(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_data(cfg_wr_data), .m_ready(m_ready), .m_valid(m_valid),
        .m_item(m_item), .obuf_free(obuf_free), .stat(stat)
    );

endmodule
